// ===== rtl/cis_pkg.sv =====
// ----------------------------------------------------------------------------
// cis_pkg
// Shared constants, types and helpers of the case-insensitive substring search.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int CHAR_BITS   = 16;
  localparam int OFFSET_BITS = 32;

  localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam int SUM_W    = (OFFSET_BITS + 1 > LEN_BITS) ? OFFSET_BITS + 1 : LEN_BITS;

  localparam int PATTERN_INDEX_W  = 6;
  localparam int CHAR_CODE_W      = 16;
  localparam int MATCH_OFFSET_W   = 32;
  localparam int PATTERN_LENGTH_W = 7;
  localparam int CFG_DATA_W       = 7;
  localparam int CFG_INDEX_W      = 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 1'b0,
    REG_CASE_SENSITIVE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_PATTERN = 1'b0,
    MODE_TEXT    = 1'b1
  } mode_t;

  typedef logic [CHAR_BITS-1:0]   char_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef struct packed {
    logic                is_text;
    logic [IDX_BITS-1:0] idx;
    char_t               ch;
    logic                last;
    offset_t             pos;
  } cis_req_t;

  function automatic char_t lower_ascii(char_t c);
    if (c >= char_t'(8'h41) && c <= char_t'(8'h5A)) begin
      return c + char_t'(8'h20);
    end
    return c;
  endfunction

endpackage

// ===== rtl/cis_if.sv =====
// ----------------------------------------------------------------------------
// cis_if
// Valid/ready channels for input requests and search results.
// ----------------------------------------------------------------------------
interface cis_item_if import cis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [PATTERN_INDEX_W-1:0] pattern_index;
  logic [CHAR_CODE_W-1:0]     char_code;
  logic                       last_of_text;

  modport source (output valid, mode, pattern_index, char_code, last_of_text, input ready);
  modport sink   (input valid, mode, pattern_index, char_code, last_of_text, output ready);
endinterface

interface cis_result_if import cis_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [MATCH_OFFSET_W-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink   (input valid, found, match_offset, output ready);
endinterface

// ===== rtl/cis_front.sv =====
// ----------------------------------------------------------------------------
// cis_front
// Accepts requests, classifies them and tags text characters with their offset.
// ----------------------------------------------------------------------------
module cis_front import cis_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  cis_item_if.sink items,
  input  logic     q_full,
  output logic     push,
  output cis_req_t req
);

  offset_t text_offset;
  logic    accept;
  logic    is_text;
  logic    idx_ok;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;
  assign is_text     = (items.mode == MODE_TEXT);
  assign idx_ok      = (32'(items.pattern_index) < 32'(MAX_PATTERN));
  assign push        = accept && (is_text || idx_ok);

  assign req.is_text = is_text;
  assign req.idx     = IDX_BITS'(items.pattern_index);
  assign req.ch      = CHAR_BITS'(items.char_code);
  assign req.last    = items.last_of_text && is_text;
  assign req.pos     = text_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_offset <= '0;
    end else if (accept && is_text) begin
      if (items.last_of_text) begin
        text_offset <= '0;
      end else if (text_offset != '1) begin
        text_offset <= text_offset + offset_t'(1);
      end
    end
  end

endmodule

// ===== rtl/cis_queue.sv =====
// ----------------------------------------------------------------------------
// cis_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module cis_queue import cis_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cis_req_t push_data,
  input  logic     pop,
  output logic     head_valid,
  output cis_req_t head,
  output logic     full
);

  cis_req_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;

  assign head_valid = (count != '0);
  assign full       = (32'(count) == 32'(QUEUE_DEPTH));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == 32'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == 32'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/cis_back.sv =====
// ----------------------------------------------------------------------------
// cis_back
// Stores pattern characters, shifts the text window, aligns it to the pattern
// length, compares all lanes and produces the single result of a text.
// ----------------------------------------------------------------------------
module cis_back import cis_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cis_req_t   head,
  output logic       pop,
  input  len_t       len,
  input  logic       case_sens,
  cis_result_if.source results
);

  char_t    window      [MAX_PATTERN];
  char_t    window_next [MAX_PATTERN];
  char_t    aligned     [MAX_PATTERN];
  char_t    s2_aligned  [MAX_PATTERN];
  char_t    pat         [MAX_PATTERN];

  logic     s1_valid;
  cis_req_t s1;
  logic     s2_valid;
  cis_req_t s2;
  logic     done;
  logic     done_next;

  logic                      res_valid;
  logic                      res_found;
  logic [MATCH_OFFSET_W-1:0] res_offset;

  logic                      adv;
  logic                      clear_win;
  logic [MAX_PATTERN-1:0]    hit;
  logic                      match;
  logic                      pos_ok;
  logic [SUM_W-1:0]          pos_p1;
  logic [SUM_W-1:0]          diff;
  logic                      emit;
  logic                      found_c;
  logic [MATCH_OFFSET_W-1:0] off_c;

  assign results.valid        = res_valid;
  assign results.found        = res_found;
  assign results.match_offset = res_offset;

  assign adv       = !res_valid || results.ready;
  assign pop       = adv && head_valid;
  assign clear_win = s1_valid && s1.is_text && s1.last;

  // shift in the new character, drop the old text after its last character
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      window_next[k] = clear_win ? '0 : window[k];
    end
    if (pop && head.is_text) begin
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
        window_next[k] = clear_win ? '0 : window[k+1];
      end
      window_next[MAX_PATTERN-1] = head.ch;
    end
  end

  // right-align the window tail to pattern lane 0
  always_comb begin
    logic [31:0] sel;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      sel = 32'(MAX_PATTERN) - 32'(len) + 32'(j);
      if (sel < 32'(MAX_PATTERN)) begin
        aligned[j] = window[sel[IDX_BITS-1:0]];
      end else begin
        aligned[j] = '0;
      end
    end
  end

  always_comb begin
    char_t t;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      t      = case_sens ? s2_aligned[j] : lower_ascii(s2_aligned[j]);
      hit[j] = (32'(j) >= 32'(len)) || (t == pat[j]);
    end
  end

  assign match  = &hit;
  assign pos_p1 = SUM_W'(s2.pos) + SUM_W'(1);
  assign pos_ok = (pos_p1 >= SUM_W'(len));
  assign diff   = pos_p1 - SUM_W'(len);

  always_comb begin
    emit      = 1'b0;
    found_c   = 1'b0;
    off_c     = '0;
    done_next = done;
    if (s2_valid && s2.is_text) begin
      if (!done) begin
        priority if (len == '0) begin
          emit      = 1'b1;
          found_c   = 1'b1;
          done_next = 1'b1;
        end else if (pos_ok && match) begin
          emit      = 1'b1;
          found_c   = 1'b1;
          off_c     = MATCH_OFFSET_W'(diff);
          done_next = 1'b1;
        end else if (s2.last) begin
          emit = 1'b1;
        end
      end
      if (s2.last) begin
        done_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      done      <= 1'b0;
      res_valid <= 1'b0;
      window    <= '{default: '0};
    end else if (adv) begin
      s1_valid  <= head_valid;
      s2_valid  <= s1_valid;
      done      <= done_next;
      res_valid <= emit;
      window    <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1         <= head;
      s2         <= s1;
      s2_aligned <= aligned;
      if (emit) begin
        res_found  <= found_c;
        res_offset <= off_c;
      end
      if (s2_valid && !s2.is_text) begin
        pat[s2.idx] <= s2.ch;
      end
    end
  end

endmodule

// ===== rtl/case_insensitive_substring_search_top.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_top
// Leftmost-match search of a loaded pattern in a stream of text characters.
//
//   channel   dir   handshake          payload
//   items     in    valid/ready        mode, pattern_index, char_code, last_of_text
//   results   out   valid/ready        found, match_offset
//   config    in    wr_en (no wait)    wr_index, wr_data
//
// One request per cycle while results are taken; a result is registered after
// its text character passes the queue, window align and lane compare stages.
// Reset clears the text window, offset, queue and result register; pattern
// entries stay undefined until loaded. A held result stalls the back part; the
// front keeps taking requests until the two-entry queue fills.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_top import cis_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  cis_item_if.sink               items,
  cis_result_if.source           results,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  len_t     cfg_len;
  logic     cfg_case;
  logic     push;
  cis_req_t req;
  logic     q_full;
  logic     head_valid;
  cis_req_t head;
  logic     pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len  <= '0;
      cfg_case <= 1'b1;
    end else if (wr_en) begin
      if (wr_index == REG_PATTERN_LENGTH) begin
        if (32'(wr_data[PATTERN_LENGTH_W-1:0]) > 32'(MAX_PATTERN)) begin
          cfg_len <= LEN_BITS'(MAX_PATTERN);
        end else begin
          cfg_len <= LEN_BITS'(wr_data[PATTERN_LENGTH_W-1:0]);
        end
      end else if (wr_index == REG_CASE_SENSITIVE) begin
        cfg_case <= wr_data[0];
      end
    end
  end

  cis_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .q_full (q_full),
    .push   (push),
    .req    (req)
  );

  cis_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (req),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  cis_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .len        (cfg_len),
    .case_sens  (cfg_case),
    .results    (results)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("request popped from an empty queue");

  a_miss_offset: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.found) |-> (results.match_offset == '0))
    else $error("not-found result carries a nonzero offset");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cfg_len) <= 32'(MAX_PATTERN))
    else $error("pattern length above the store depth");

endmodule
